@@ hdl/htcg_pkg.sv @@
// Shared types and constants for the hold-to-commit gesture block.
// No dependencies; imported by hold_to_commit_gesture_top.
package htcg_pkg;

   // Gesture phases, encoded as reported in phase_now
   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_SAVING   = 3'd1,
      PH_LOADING  = 3'd2,
      PH_FLASH    = 3'd3,
      PH_DISARMED = 3'd4
   } phase_type;

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_EDGE_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_NEUTRAL_LOW    = 3'd1;
   localparam logic [2:0] CSR_NEUTRAL_HIGH   = 3'd2;
   localparam logic [2:0] CSR_HOLD_TIME      = 3'd3;
   localparam logic [2:0] CSR_FLASH_TIME     = 3'd4;
   localparam logic [2:0] CSR_STORE_ATTACHED = 3'd5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int POS_W      = 12;
   localparam int MS_W       = 16;

   // Position value of full travel (1.0 in Q0.12)
   localparam logic [POS_W:0] FULL_SCALE = 13'd4096;

   // Reset values of the configuration registers
   localparam logic [POS_W-1:0] EDGE_THRESHOLD_RST = 12'd205;
   localparam logic [POS_W-1:0] NEUTRAL_LOW_RST    = 12'd1638;
   localparam logic [POS_W-1:0] NEUTRAL_HIGH_RST   = 12'd2458;
   localparam logic [MS_W-1:0]  HOLD_TIME_RST      = 16'd1000;
   localparam logic [MS_W-1:0]  FLASH_TIME_RST     = 16'd600;

   typedef struct packed {
      logic [11:0] slot_pos;
      logic [11:0] action_pos;
      logic [7:0]  elapsed_ms;
      logic        store_ok;
   } req_type;

   typedef struct packed {
      logic        committed;
      logic        commit_is_save;
      logic [2:0]  commit_slot;
      logic        commit_ok;
      logic [2:0]  phase_now;
      logic [15:0] hold_elapsed;
      logic [15:0] flash_elapsed;
      logic [2:0]  shown_slot;
   } rsp_type;

endpackage

@@ hdl/hold_to_commit_gesture_top.sv @@
// Hold-to-commit save/load gesture: phase machine, hold and flash timers, slot mapping.
// Depends on htcg_pkg.
//
// Each accepted request beat yields a registered response beat in the next cycle.
// Throughput: one beat per cycle unless the output stalls; the gesture state
// updates in a single pass and a response register decouples the output side.
// Reset (synchronous, active high) clears the phase to idle, both timers, the
// latched gesture and restores the configuration register defaults.
module hold_to_commit_gesture_top #(
   parameter int NUM_SLOTS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  htcg_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output htcg_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [htcg_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [htcg_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import htcg_pkg::*;

   localparam int NW = $clog2(NUM_SLOTS + 1);
   localparam logic [NW-1:0] SLOT_MAX = NW'(NUM_SLOTS - 1);

   // configuration
   logic [POS_W-1:0] edge_thr_ff, neutral_low_ff, neutral_high_ff;
   logic [MS_W-1:0]  hold_time_ff, flash_time_ff;
   logic             attached_ff;

   // gesture state
   phase_type        phase_ff, phase_in;
   logic [MS_W-1:0]  hold_ff, hold_in, flash_ff, flash_in;
   logic             armed_save_ff, armed_save_in;
   logic [2:0]       armed_slot_ff, armed_slot_in;
   logic             last_ok_ff, last_ok_in;

   // response register
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             commit;
   logic [POS_W+NW-1:0] slot_prod;
   logic [NW-1:0]    slot_raw, slot_cap;
   logic [2:0]       cur_slot;
   logic [POS_W:0]   load_sum;
   logic             at_save, at_load, neutral, still;
   logic [MS_W:0]    hold_sum, flash_sum;
   logic [MS_W-1:0]  hold_sat, flash_sat;

   // take a new beat whenever the response register is empty or draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_thr_ff     <= EDGE_THRESHOLD_RST;
         neutral_low_ff  <= NEUTRAL_LOW_RST;
         neutral_high_ff <= NEUTRAL_HIGH_RST;
         hold_time_ff    <= HOLD_TIME_RST;
         flash_time_ff   <= FLASH_TIME_RST;
         attached_ff     <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_EDGE_THRESHOLD: edge_thr_ff     <= csr_wdata[POS_W-1:0];
            CSR_NEUTRAL_LOW:    neutral_low_ff  <= csr_wdata[POS_W-1:0];
            CSR_NEUTRAL_HIGH:   neutral_high_ff <= csr_wdata[POS_W-1:0];
            CSR_HOLD_TIME:      hold_time_ff    <= csr_wdata;
            CSR_FLASH_TIME:     flash_time_ff   <= csr_wdata;
            CSR_STORE_ATTACHED: attached_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // map selector position to a slot, capped at the last slot
   always_comb begin
      slot_prod = (POS_W+NW)'(req_data.slot_pos) * (POS_W+NW)'(NUM_SLOTS);
      slot_raw  = slot_prod[POS_W+NW-1:POS_W];
      slot_cap  = (slot_raw > SLOT_MAX) ? SLOT_MAX : slot_raw;
      cur_slot  = 3'(slot_cap);
   end

   // classify action position and run saturating timers
   always_comb begin
      load_sum  = {1'b0, req_data.action_pos} + {1'b0, edge_thr_ff};
      at_save   = req_data.action_pos <= edge_thr_ff;
      at_load   = load_sum >= FULL_SCALE;
      neutral   = (req_data.action_pos >= neutral_low_ff) &&
                  (req_data.action_pos <= neutral_high_ff);
      hold_sum  = {1'b0, hold_ff} + (MS_W+1)'(req_data.elapsed_ms);
      flash_sum = {1'b0, flash_ff} + (MS_W+1)'(req_data.elapsed_ms);
      hold_sat  = hold_sum[MS_W] ? {MS_W{1'b1}} : hold_sum[MS_W-1:0];
      flash_sat = flash_sum[MS_W] ? {MS_W{1'b1}} : flash_sum[MS_W-1:0];
      still     = (phase_ff == PH_SAVING) ? at_save : at_load;
   end

   // next state of the gesture
   always_comb begin
      phase_in      = phase_ff;
      hold_in       = hold_ff;
      flash_in      = flash_ff;
      armed_save_in = armed_save_ff;
      armed_slot_in = armed_slot_ff;
      last_ok_in    = last_ok_ff;
      commit        = 1'b0;
      if (attached_ff) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (at_save || at_load) begin
                  phase_in      = at_save ? PH_SAVING : PH_LOADING;
                  hold_in       = '0;
                  armed_save_in = at_save;
                  armed_slot_in = cur_slot;
               end
            end
            PH_SAVING, PH_LOADING: begin
               if (!still) begin
                  phase_in = PH_IDLE;
                  hold_in  = '0;
               end else if (hold_sat >= hold_time_ff) begin
                  last_ok_in = req_data.store_ok;
                  commit     = 1'b1;
                  phase_in   = req_data.store_ok ? PH_FLASH : PH_DISARMED;
                  flash_in   = '0;
                  hold_in    = '0;
               end else begin
                  hold_in = hold_sat;
               end
            end
            PH_FLASH: begin
               if (flash_sat >= flash_time_ff) begin
                  phase_in = PH_DISARMED;
                  flash_in = '0;
               end else begin
                  flash_in = flash_sat;
               end
            end
            default: begin
               if (neutral) phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // assemble the response beat
   always_comb begin
      rsp_in.committed      = commit;
      rsp_in.commit_is_save = armed_save_in;
      rsp_in.commit_slot    = armed_slot_in;
      rsp_in.commit_ok      = last_ok_in;
      rsp_in.phase_now      = phase_in;
      rsp_in.hold_elapsed   = hold_in;
      rsp_in.flash_elapsed  = flash_in;
      rsp_in.shown_slot     = cur_slot;
   end

   // advance gesture state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         hold_ff       <= '0;
         flash_ff      <= '0;
         armed_save_ff <= 1'b0;
         armed_slot_ff <= '0;
         last_ok_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         hold_ff       <= hold_in;
         flash_ff      <= flash_in;
         armed_save_ff <= armed_save_in;
         armed_slot_ff <= armed_slot_in;
         last_ok_ff    <= last_ok_in;
      end
   end

   // hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a commit always leaves the gesture flashing or disarmed
   a_commit_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.committed |->
         (rsp_ff.phase_now == PH_FLASH) || (rsp_ff.phase_now == PH_DISARMED))
      else $error("commit left gesture in an armed or idle phase");

   // an empty response register never stalls the request side
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("request stalled with empty response register");

   // hold timer runs only while a gesture is armed
   a_hold_phase: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_SAVING) && (phase_ff != PH_LOADING) |-> hold_ff == '0)
      else $error("hold timer nonzero outside an armed phase");

   // flash timer runs only during the flash phase
   a_flash_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_FLASH |-> flash_ff == '0)
      else $error("flash timer nonzero outside flash phase");

endmodule
